/* src/lrl_pkg.sv */
// Shared types, constants and helper function of the sliding-window log rate limiter.
package lrl_pkg;

  localparam int NUM_CLIENTS = 64;
  localparam int LOG_DEPTH   = 64;

  localparam int CL_AW  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int HEAD_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int TL_AW  = $clog2(NUM_CLIENTS * LOG_DEPTH);
  localparam int MAXREQ_W = 7;
  localparam int LIM_W  = (CNT_W > MAXREQ_W) ? CNT_W : MAXREQ_W;

  localparam int PADDR_W = 4;

  localparam logic [1:0] OP_CHECK   = 2'd0;
  localparam logic [1:0] OP_BLOCK   = 2'd1;
  localparam logic [1:0] OP_UNBLOCK = 2'd2;
  localparam logic [1:0] OP_RESET   = 2'd3;

  localparam logic [1:0] REG_MAX_REQUESTS   = 2'd0;
  localparam logic [1:0] REG_WINDOW_SECONDS = 2'd1;
  localparam logic [1:0] REG_BLOCK_SECONDS  = 2'd2;

  localparam logic [6:0]  RST_MAX_REQUESTS   = 7'd60;
  localparam logic [15:0] RST_WINDOW_SECONDS = 16'd60;
  localparam logic [15:0] RST_BLOCK_SECONDS  = 16'd3600;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  client;
    logic [31:0] now_seconds;
    logic [15:0] block_duration;
  } in_item_t;

  typedef struct packed {
    logic       allowed;
    logic [6:0] window_count;
    logic       client_blocked;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  req_cap;
    logic [15:0] window_span;
    logic [15:0] block_seconds;
  } cfg_t;

  // Per-client bookkeeping as it sits in the client memory.
  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [CNT_W-1:0]  count;
    logic              blocked;
    logic [31:0]       release_time;
  } client_rec_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic pop;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       in_range;
    logic       hold;
    logic       cnt_zero;
    logic       expired;
    logic       out_free;
  } stat_t;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

/* src/sliding_log_rate_limiter_unit.sv */
// Top level of the sliding-window log rate limiter.
//
// Each input transaction names a client, the current time in seconds and an
// operation: check a request, block the client, unblock it, or clear it.
// Every input transaction produces exactly one output transaction carrying
// the admit decision, the client's live log count and its blocked flag.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. Configuration (request limit, window, block time) is written through the
// APB-style port; the user must do so only while idle, as the block does not enforce it.
//
// One transaction is processed at a time. Block, unblock, clear and a check
// that hits a still-blocked client go from fetch straight to commit. Other
// checks wait for the read of the oldest live entry, compare it unless the
// log is empty, and pop and read again for each expired entry; the single
// read port of the time-log memory sets that per-entry cost.
// The result appears in the output register the cycle after commit.
// A stalled receiver holds the result in the output register; the block
// finishes its current transaction and waits there before committing.
// Reset clears the sequencer, the output valid and the per-client valid bits,
// so every client starts unblocked with an empty log; no clearing pass runs.
module sliding_log_rate_limiter_unit
  import lrl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Configuration registers.
  lrl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The sequencer decides which step runs; the datapath carries it out.
  lrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrl_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* src/lrl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/lrl_cfg.sv */
// Configuration register file behind the APB-style port.
module lrl_cfg
  import lrl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.req_cap       <= RST_MAX_REQUESTS;
      cfg.window_span   <= RST_WINDOW_SECONDS;
      cfg.block_seconds <= RST_BLOCK_SECONDS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_REQUESTS:   cfg.req_cap       <= pwdata[6:0];
        REG_WINDOW_SECONDS: cfg.window_span   <= pwdata[15:0];
        REG_BLOCK_SECONDS:  cfg.block_seconds <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_REQUESTS:   prdata = 32'(cfg.req_cap);
      REG_WINDOW_SECONDS: prdata = 32'(cfg.window_span);
      REG_BLOCK_SECONDS:  prdata = 32'(cfg.block_seconds);
      default:            prdata = 32'd0;
    endcase
  end

endmodule

/* src/lrl_ctrl.sv */
// Sequencer that steps one transaction through fetch, expiry and commit.
module lrl_ctrl
  import lrl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXP_RD,
    S_EXP_CMP,
    S_FINISH
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (stat.in_range && (stat.op == OP_CHECK) && !stat.hold) begin
          state_next = S_EXP_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_EXP_RD: begin
        // The oldest entry's read is under way; nothing to read if the log is empty.
        state_next = stat.cnt_zero ? S_FINISH : S_EXP_CMP;
      end
      S_EXP_CMP: begin
        if (stat.expired) begin
          cmd.pop    = 1'b1;
          state_next = S_EXP_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/lrl_dpath.sv */
// Datapath: item and working registers, client and time-log memories, result register.
module lrl_dpath
  import lrl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  in_item_t          item;
  logic [CL_AW-1:0]  idx;
  logic [TL_AW-1:0]  base;
  logic              in_range;
  logic              hold;

  logic [HEAD_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic              blocked;
  logic [31:0]       release_time;

  logic [NUM_CLIENTS-1:0] cl_valid;

  client_rec_t cl_rdata, fetched, new_rec;
  logic        fetch_hold;
  logic        cl_we;

  logic [31:0]       tl_rdata;
  logic [TL_AW-1:0]  tl_raddr, tl_waddr;
  logic              tl_we;
  logic [CNT_W:0]    tail_sum;
  logic [HEAD_W-1:0] tail;
  logic [HEAD_W-1:0] head_inc;

  logic [LIM_W-1:0] limit;
  logic             at_limit;
  logic [15:0]      add_len;
  logic [31:0]      sat_release;
  logic             res_allowed;
  logic [32:0]      expiry_sum;

  lrl_ram #(.WIDTH($bits(client_rec_t)), .DEPTH(NUM_CLIENTS)) u_client_ram (
    .clk   (clk),
    .we    (cl_we),
    .waddr (idx),
    .wdata (new_rec),
    .raddr (CL_AW'(in_data.client)),
    .rdata (cl_rdata)
  );

  lrl_ram #(.WIDTH(32), .DEPTH(NUM_CLIENTS * LOG_DEPTH)) u_time_log (
    .clk   (clk),
    .we    (tl_we),
    .waddr (tl_waddr),
    .wdata (item.now_seconds),
    .raddr (tl_raddr),
    .rdata (tl_rdata)
  );

  // A client never written since reset reads as all zero.
  assign fetched    = cl_valid[idx] ? cl_rdata : '0;
  assign fetch_hold = (item.op == OP_CHECK) && fetched.blocked &&
                      (item.now_seconds < fetched.release_time);

  assign head_inc = (head == HEAD_W'(LOG_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  assign tail     = (tail_sum >= (CNT_W+1)'(LOG_DEPTH)) ?
                    HEAD_W'(tail_sum - (CNT_W+1)'(LOG_DEPTH)) : HEAD_W'(tail_sum);
  assign tl_raddr = base + TL_AW'(head);
  assign tl_waddr = base + TL_AW'(tail);

  assign expiry_sum = {1'b0, tl_rdata} + 33'(cfg.window_span);

  assign limit    = (LIM_W'(cfg.req_cap) > LIM_W'(LOG_DEPTH)) ?
                    LIM_W'(LOG_DEPTH) : LIM_W'(cfg.req_cap);
  assign at_limit = LIM_W'(count) >= limit;
  assign add_len  = (item.op == OP_BLOCK) ? item.block_duration : cfg.block_seconds;
  assign sat_release = sat_add(item.now_seconds, add_len);

  always_comb begin
    stat.op       = item.op;
    stat.in_range = in_range;
    stat.hold     = fetch_hold;
    stat.cnt_zero = (count == '0);
    stat.expired  = expiry_sum < {1'b0, item.now_seconds};
    stat.out_free = !out_valid || !out_stall;
  end

  // Outcome of the item, applied at commit.
  always_comb begin
    new_rec.head         = head;
    new_rec.count        = count;
    new_rec.blocked      = blocked;
    new_rec.release_time = release_time;
    res_allowed          = 1'b0;
    tl_we                = 1'b0;
    case (item.op)
      OP_CHECK: begin
        if (!hold) begin
          if (at_limit) begin
            new_rec.blocked      = 1'b1;
            new_rec.release_time = sat_release;
          end else begin
            new_rec.count = count + 1'b1;
            res_allowed   = 1'b1;
            tl_we         = cmd.commit && in_range;
          end
        end
      end
      OP_BLOCK: begin
        new_rec.blocked      = 1'b1;
        new_rec.release_time = sat_release;
      end
      OP_UNBLOCK: new_rec.blocked = 1'b0;
      OP_RESET:   new_rec = '0;
      default: ;
    endcase
  end

  assign cl_we = cmd.commit && in_range;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item     <= in_data;
      idx      <= CL_AW'(in_data.client);
      base     <= TL_AW'(CL_AW'(in_data.client)) * TL_AW'(LOG_DEPTH);
      in_range <= int'(in_data.client) < NUM_CLIENTS;
    end
    if (cmd.fetch) begin
      hold         <= fetch_hold;
      release_time <= fetched.release_time;
      if ((item.op == OP_CHECK) && fetched.blocked && !fetch_hold) begin
        // Block has run out: lift it and start with an empty log.
        blocked <= 1'b0;
        head    <= '0;
        count   <= '0;
      end else begin
        blocked <= fetched.blocked;
        head    <= fetched.head;
        count   <= fetched.count;
      end
    end else if (cmd.pop) begin
      head  <= head_inc;
      count <= count - 1'b1;
    end
    if (cmd.commit) begin
      if (in_range) begin
        out_data.allowed        <= res_allowed;
        out_data.window_count   <= 7'(new_rec.count);
        out_data.client_blocked <= new_rec.blocked;
      end else begin
        out_data <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_valid  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cl_we) begin
        cl_valid[idx] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/lrl_checker.sv */
// Port-level checker for the rate limiter and its bind to the top level.
module lrl_checker
  import lrl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Only one transaction is in flight: the input stalls after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  // An admitted request leaves the client unblocked with at least one entry.
  a_allow_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.allowed) |->
      (!out_data.client_blocked && (out_data.window_count != 7'd0)))
    else $error("admitted request with inconsistent status");

  // The log never reports more entries than it can hold.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.window_count) <= LOG_DEPTH))
    else $error("window count above log depth");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // The input side is not inspected beyond the handshake.
  logic unused_in;
  assign unused_in = ^in_data;

endmodule

bind sliding_log_rate_limiter_unit lrl_checker u_lrl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/tb_sliding_log_rate_limiter_unit.sv */
// Self-checking testbench for the sliding-window log rate limiter top level.
`timescale 1ns / 100ps

// Keeps its own copy of every client's log, block flag and release time,
// predicts the verdict of each accepted request and compares the results.
class limiter_scoreboard;
  bit [31:0]             stamp_log [lrl_pkg::NUM_CLIENTS][lrl_pkg::LOG_DEPTH];
  bit [lrl_pkg::HEAD_W-1:0] oldest_slot [lrl_pkg::NUM_CLIENTS];
  bit [lrl_pkg::CNT_W-1:0]  live_count [lrl_pkg::NUM_CLIENTS];
  bit                    held_off [lrl_pkg::NUM_CLIENTS];
  bit [31:0]             release_at [lrl_pkg::NUM_CLIENTS];

  bit [6:0]  req_limit;
  bit [15:0] window_len;
  bit [15:0] penalty_len;

  lrl_pkg::out_item_t expected_verdicts [$];
  int mismatches;
  int results_checked;

  function new();
    for (int i = 0; i < lrl_pkg::NUM_CLIENTS; i++) begin
      forget_client(i);
    end
    req_limit   = lrl_pkg::RST_MAX_REQUESTS;
    window_len  = lrl_pkg::RST_WINDOW_SECONDS;
    penalty_len = lrl_pkg::RST_BLOCK_SECONDS;
    mismatches      = 0;
    results_checked = 0;
  endfunction

  function void forget_client(int who);
    oldest_slot[who] = '0;
    live_count[who]  = '0;
    held_off[who]    = 1'b0;
    release_at[who]  = '0;
  endfunction

  function void set_register(logic [1:0] idx, logic [31:0] value);
    case (idx)
      lrl_pkg::REG_MAX_REQUESTS:   req_limit   = value[6:0];
      lrl_pkg::REG_WINDOW_SECONDS: window_len  = value[15:0];
      lrl_pkg::REG_BLOCK_SECONDS:  penalty_len = value[15:0];
      default: ;
    endcase
  endfunction

  function bit [31:0] release_time_of(bit [31:0] now, bit [15:0] span);
    bit [32:0] total;
    total = {1'b0, now} + {17'b0, span};
    return total[32] ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  // Admission decision for one check; updates the client's state.
  function bit admit_request(int who, bit [31:0] now);
    bit [6:0]                 cap;
    bit [lrl_pkg::HEAD_W-1:0] slot;
    bit [32:0]                horizon;
    cap = (req_limit > lrl_pkg::LOG_DEPTH) ? 7'(lrl_pkg::LOG_DEPTH) : req_limit;
    if (held_off[who]) begin
      if (now < release_at[who]) return 1'b0;
      // The block has run out: lift it and start over with an empty log.
      held_off[who]    = 1'b0;
      oldest_slot[who] = '0;
      live_count[who]  = '0;
    end
    // Drop stale entries from the oldest end only.
    while (live_count[who] > 0) begin
      horizon = {1'b0, stamp_log[who][oldest_slot[who]]} + {17'b0, window_len};
      if (horizon >= {1'b0, now}) break;
      oldest_slot[who] = oldest_slot[who] + 1'b1;
      live_count[who]  = live_count[who] - 1'b1;
    end
    if (live_count[who] >= cap) begin
      held_off[who]   = 1'b1;
      release_at[who] = release_time_of(now, penalty_len);
      return 1'b0;
    end
    slot = oldest_slot[who] + lrl_pkg::HEAD_W'(live_count[who]);
    stamp_log[who][slot] = now;
    live_count[who] = live_count[who] + 1'b1;
    return 1'b1;
  endfunction

  function void note_input(lrl_pkg::in_item_t req);
    lrl_pkg::out_item_t verdict;
    int who;
    who = req.client;
    verdict.allowed = 1'b0;
    case (req.op)
      lrl_pkg::OP_CHECK: verdict.allowed = admit_request(who, req.now_seconds);
      lrl_pkg::OP_BLOCK: begin
        held_off[who]   = 1'b1;
        release_at[who] = release_time_of(req.now_seconds, req.block_duration);
      end
      lrl_pkg::OP_UNBLOCK: held_off[who] = 1'b0;
      default: forget_client(who);
    endcase
    verdict.window_count   = 7'(live_count[who]);
    verdict.client_blocked = held_off[who];
    expected_verdicts.insert(expected_verdicts.size(), verdict);
  endfunction

  function void check_result(lrl_pkg::out_item_t got);
    lrl_pkg::out_item_t want;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected result transaction: allowed %0d window_count %0d client_blocked %0d",
             got.allowed, got.window_count, got.client_blocked);
      mismatches++;
      return;
    end
    want = expected_verdicts.pop_front();
    results_checked++;
    if (got.allowed !== want.allowed) begin
      $error("allowed: expected %0d, actual %0d", want.allowed, got.allowed);
      mismatches++;
    end
    if (got.window_count !== want.window_count) begin
      $error("window_count: expected %0d, actual %0d", want.window_count, got.window_count);
      mismatches++;
    end
    if (got.client_blocked !== want.client_blocked) begin
      $error("client_blocked: expected %0d, actual %0d",
             want.client_blocked, got.client_blocked);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_verdicts.size();
  endfunction
endclass

module tb_sliding_log_rate_limiter_unit;
  import lrl_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  // It leaves room for the slowest check, which pops a full log of 64 entries,
  // and for the receiver's stall runs.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settle time once the last result is in; covers the longest check.
  localparam int DRAIN_CYCLES   = 200;

  // Where the clock of a phase starts.
  localparam int BASE_KEEP   = 0;
  localparam int BASE_ZERO   = 1;
  localparam int BASE_RANDOM = 2;
  localparam int BASE_TOP    = 3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  limiter_scoreboard sb = new();

  // Stimulus state: the simulated wall clock, the clients a phase hammers,
  // and the shape of the sender's bursts.
  bit [31:0]   wall_time;
  int unsigned cur_window;
  int unsigned hot_count;
  bit [5:0]    hot_client [4];
  int          burst_left;
  int          stall_left;
  int          idle_cycles;
  int          items_sent;
  int          settings_used;

  sliding_log_rate_limiter_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The monitor samples both channels at the rising edge. The input side is
  // noted first: a result can never belong to the request accepted at the
  // same edge, so this order is always safe. The watchdog shares the block.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results still outstanding.", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver stalls in short random runs, broken now and then by long
  // calm stretches so that results also pass without any stall.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if ($urandom_range(0, 9) < 2) begin
          out_stall  <= 1'b0;
          stall_left = $urandom_range(30, 150);
        end else begin
          out_stall  <= 1'($urandom_range(0, 1));
          stall_left = $urandom_range(0, 9);
        end
      end else begin
        stall_left--;
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [5:0] client,
                                         logic [31:0] now, logic [15:0] dur);
    in_item_t item;
    item.op             = op;
    item.client         = client;
    item.now_seconds    = now;
    item.block_duration = dur;
    return item;
  endfunction

  // Offers one request transaction and holds it until accepted. The sender
  // works in bursts; valid drops between bursts and, mid-burst, only in wait_idle.
  task automatic send_item(input in_item_t item);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 14)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Drops valid and waits until every outstanding result has come back, so
  // that the block is idle and a register write is safe.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready. The upper
  // bits of pwdata carry noise the register must ignore.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] word;
    case (idx)
      REG_MAX_REQUESTS: word = {25'($urandom_range(0, 32'h01FF_FFFF)), 7'b0} | value;
      default:          word = {16'($urandom_range(0, 65535)), 16'b0} | value;
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, word);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random request: mostly checks on a few hot clients with a slowly moving
  // clock, so logs fill, hit the limit, block and expire. The rest is
  // direct block management, stray clients and jumps of the clock, some of
  // them backwards.
  function automatic in_item_t random_item();
    int unsigned pick;
    int unsigned delta;
    logic [1:0]  op;
    logic [5:0]  client;
    logic [15:0] dur;
    pick = $urandom_range(0, 99);
    if (pick < 45) delta = 0;
    else if (pick < 85) delta = $urandom_range(1, 3);
    else if (pick < 95) delta = $urandom_range(4, cur_window * 2 + 4);
    else if (pick < 98) delta = 0;
    else delta = $urandom_range(0, 32'h0010_0000);
    if (pick >= 95 && pick < 98) begin
      if (wall_time >= 5) wall_time = wall_time - $urandom_range(1, 5);
    end else if (wall_time > 32'hFFFF_FFFF - delta) begin
      wall_time = 32'hFFFF_FFFF;
    end else begin
      wall_time = wall_time + delta;
    end

    pick = $urandom_range(0, 99);
    if (pick < 82) op = OP_CHECK;
    else if (pick < 88) op = OP_BLOCK;
    else if (pick < 94) op = OP_UNBLOCK;
    else op = OP_RESET;

    if ($urandom_range(0, 99) < 85) client = hot_client[$urandom_range(0, hot_count - 1)];
    else client = 6'($urandom_range(0, NUM_CLIENTS - 1));

    pick = $urandom_range(0, 99);
    if (pick < 25) dur = 16'($urandom_range(0, 3));
    else if (pick < 40) dur = 16'hFFFF;
    else dur = 16'($urandom_range(0, 65535));

    return make_item(op, client, wall_time, dur);
  endfunction

  // One setting of the registers followed by a run of random requests.
  task automatic run_phase(input int unsigned max_req, input int unsigned win,
                           input int unsigned blk, input int unsigned hot,
                           input int base_kind, input int n_items);
    wait_idle();
    write_register(REG_MAX_REQUESTS, 32'(max_req));
    write_register(REG_WINDOW_SECONDS, 32'(win));
    write_register(REG_BLOCK_SECONDS, 32'(blk));
    settings_used++;
    cur_window = win;
    hot_count  = hot;
    foreach (hot_client[i]) hot_client[i] = 6'($urandom_range(0, NUM_CLIENTS - 1));
    case (base_kind)
      BASE_ZERO:   wall_time = '0;
      BASE_RANDOM: wall_time = $urandom;
      BASE_TOP:    wall_time = 32'hFFFF_FF00 | $urandom_range(0, 255);
      default: ;
    endcase
    repeat (n_items) send_item(random_item());
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    wall_time     = '0;
    cur_window    = 60;
    hot_count     = 1;
    burst_left    = 0;
    items_sent    = 0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A couple of checks under the reset values of the registers.
    send_item(make_item(OP_CHECK, 6'd5, 32'd0, 16'd0));
    send_item(make_item(OP_CHECK, 6'd5, 32'd59, 16'hFFFF));

    // Directed part under a tight limit of two per ten seconds.
    wait_idle();
    write_register(REG_MAX_REQUESTS, 32'd2);
    write_register(REG_WINDOW_SECONDS, 32'd10);
    write_register(REG_BLOCK_SECONDS, 32'd5);
    settings_used++;
    cur_window = 10;

    // Fill the log, hit the limit, stay denied, then come out of the block.
    send_item(make_item(OP_CHECK, 6'd0, 32'd0, 16'd0));
    send_item(make_item(OP_CHECK, 6'd0, 32'd0, 16'd0));
    send_item(make_item(OP_CHECK, 6'd0, 32'd0, 16'd0));
    send_item(make_item(OP_CHECK, 6'd0, 32'd3, 16'd0));
    send_item(make_item(OP_CHECK, 6'd0, 32'd5, 16'd0));
    // A block of zero length releases on the very next check.
    send_item(make_item(OP_BLOCK, 6'd0, 32'd6, 16'd0));
    send_item(make_item(OP_CHECK, 6'd0, 32'd6, 16'd0));
    send_item(make_item(OP_CHECK, 6'd0, 32'd7, 16'd0));
    // Unblock lifts the flag but keeps the log.
    send_item(make_item(OP_BLOCK, 6'd0, 32'd7, 16'hFFFF));
    send_item(make_item(OP_UNBLOCK, 6'd0, 32'd8, 16'd0));
    // One entry falls out of the window, the other sits exactly at its edge and stays.
    send_item(make_item(OP_CHECK, 6'd0, 32'd17, 16'd0));
    send_item(make_item(OP_CHECK, 6'd0, 32'd40, 16'd0));
    send_item(make_item(OP_RESET, 6'd0, 32'd40, 16'hFFFF));
    // Near the top of the clock the release time saturates.
    send_item(make_item(OP_CHECK, 6'd63, 32'hFFFF_FFF0, 16'd0));
    send_item(make_item(OP_CHECK, 6'd63, 32'hFFFF_FFF0, 16'd0));
    send_item(make_item(OP_CHECK, 6'd63, 32'hFFFF_FFFE, 16'd0));
    send_item(make_item(OP_BLOCK, 6'd63, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_item(OP_CHECK, 6'd63, 32'hFFFF_FFFF, 16'd0));
    // The clock running backwards expires nothing.
    send_item(make_item(OP_CHECK, 6'd63, 32'd100, 16'd0));
    send_item(make_item(OP_CHECK, 6'd63, 32'd100, 16'd0));
    send_item(make_item(OP_UNBLOCK, 6'd63, 32'd100, 16'd0));
    send_item(make_item(OP_RESET, 6'd63, 32'd100, 16'd0));

    // Random phases: limit, window, block time, hot clients, clock start.
    run_phase(3,   10,    20,    2, BASE_ZERO,   106);
    run_phase(1,   1,     1,     3, BASE_RANDOM, 106);
    run_phase(127, 65535, 65535, 1, BASE_ZERO,   106);
    run_phase(0,   5,     7,     2, BASE_KEEP,   106);
    run_phase(64,  100,   0,     1, BASE_TOP,    106);
    run_phase(8,   4,     50,    4, BASE_RANDOM, 106);
    run_phase(2,   65535, 3,     3, BASE_TOP,    106);
    run_phase(5,   0,     12,    2, BASE_RANDOM, 106);
    run_phase(16,  2,     9,     2, BASE_KEEP,   106);
    run_phase(60,  60,    3600,  4, BASE_RANDOM, 106);
    run_phase(6,   20,    1000,  3, BASE_ZERO,   106);
    run_phase(3,   7,     65535, 2, BASE_TOP,    106);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request transactions under %0d register settings;",
             items_sent, settings_used);
    $display("checked %0d results, %0d field mismatches.", sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
